@@ rtl/core/i2a_pkg.sv @@
// Package: shared types, constants and helper functions for the integer-to-ASCII core.
`default_nettype none
package i2a_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CharW   = 8;
  localparam int unsigned LenW    = 5;
  localparam int unsigned MaxChars = 22;
  localparam int unsigned BcdDigits = 20;
  localparam int unsigned BcdW    = 4 * BcdDigits;
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned DabbleStages = ValueW / StepsPerStage;

  typedef enum logic [KindW-1:0] {
    KIND_HEX = 2'd0,
    KIND_OCT = 2'd1,
    KIND_UDEC = 2'd2,
    KIND_SDEC = 2'd3
  } kind_t;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharAlpha = 8'h57;  // 'a' - 10
  localparam logic [CharW-1:0] CharMinus = 8'h2d;

  typedef logic [MaxChars-1:0][3:0] digits_t;

  // Converted item handed from the pipeline to the serializer.
  typedef struct packed {
    digits_t             digits;
    logic [LenW-1:0]     ndig;
    logic                neg;
    logic [LenW-1:0]     len;
  } fmt_t;

  // One shift-and-add-3 step: adjust each BCD digit, then shift in one bit.
  function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                  input logic bit_in);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int d = 0; d < BcdDigits; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) return CharZero + {4'd0, d};
    return CharAlpha + {4'd0, d};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/i2a_if.sv @@
// Interfaces: request and response word channels.
`default_nettype none
interface i2a_req_if;
  logic                         valid;
  logic                         ready;
  logic [i2a_pkg::KindW-1:0]    kind;
  logic [i2a_pkg::ValueW-1:0]   value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface i2a_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [i2a_pkg::CharW-1:0]    character;
  logic                         last;
  logic [i2a_pkg::LenW-1:0]     length;
  modport source (output valid, character, last, length, input ready);
  modport sink   (input valid, character, last, length, output ready);
endinterface
`default_nettype wire

@@ rtl/core/i2a_pipe.sv @@
// Conversion pipeline: magnitude stage, eight double-dabble stages, digit format stage.
`default_nettype none
module i2a_pipe (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [i2a_pkg::KindW-1:0]  in_kind,
  input  wire logic [i2a_pkg::ValueW-1:0] in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output i2a_pkg::fmt_t                   out_fmt
);
  import i2a_pkg::*;

  logic advance;

  // stage 0
  logic              v0;
  kind_t             kind0;
  logic              neg0;
  logic [ValueW-1:0] raw0;

  // dabble stages
  logic [DabbleStages-1:0]             vd;
  kind_t                               kindd [DabbleStages];
  logic                                negd  [DabbleStages];
  logic [ValueW-1:0]                   rawd  [DabbleStages];
  logic [BcdW-1:0]                     bcdd  [DabbleStages];

  // format stage
  logic  v9;
  fmt_t  fmt9;

  assign advance  = !v9 || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= in_valid;
    end
    if (advance) begin
      kind0 <= kind_t'(in_kind);
      neg0  <= (kind_t'(in_kind) == KIND_SDEC) && in_value[ValueW-1];
      raw0  <= ((kind_t'(in_kind) == KIND_SDEC) && in_value[ValueW-1]) ?
               (~in_value + 64'd1) : in_value;
    end
  end

  for (genvar s = 0; s < DabbleStages; s++) begin : g_dab
    logic              vin;
    kind_t             kin;
    logic              nin;
    logic [ValueW-1:0] rin;
    logic [BcdW-1:0]   bin;
    logic [BcdW-1:0]   bout;

    if (s == 0) begin : g_first
      assign vin = v0;
      assign kin = kind0;
      assign nin = neg0;
      assign rin = raw0;
      assign bin = '0;
    end else begin : g_rest
      assign vin = vd[s-1];
      assign kin = kindd[s-1];
      assign nin = negd[s-1];
      assign rin = rawd[s-1];
      assign bin = bcdd[s-1];
    end

    always_comb begin
      bout = bin;
      for (int k = 0; k < StepsPerStage; k++) begin
        bout = dabble_step(bout, rin[ValueW-1-(s*StepsPerStage)-k]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s] <= 1'b0;
      end else if (advance) begin
        vd[s] <= vin;
      end
      if (advance) begin
        kindd[s] <= kin;
        negd[s]  <= nin;
        rawd[s]  <= rin;
        bcdd[s]  <= bout;
      end
    end
  end

  // digit select and leading-digit count
  kind_t             kf;
  logic [ValueW-1:0] rf;
  logic [BcdW-1:0]   bf;
  logic [ValueW+1:0] oct_ext;
  digits_t           dig;
  logic [LenW-1:0]   nd;

  assign kf      = kindd[DabbleStages-1];
  assign rf      = rawd[DabbleStages-1];
  assign bf      = bcdd[DabbleStages-1];
  assign oct_ext = {2'b00, rf};

  always_comb begin
    dig = '0;
    unique case (kf)
      KIND_HEX: for (int j = 0; j < 16; j++) dig[j] = rf[4*j +: 4];
      KIND_OCT: for (int j = 0; j < MaxChars; j++) dig[j] = {1'b0, oct_ext[3*j +: 3]};
      default:  for (int j = 0; j < BcdDigits; j++) dig[j] = bf[4*j +: 4];
    endcase
    nd = 5'd1;
    for (int j = 0; j < MaxChars; j++) begin
      if (dig[j] != 4'd0) nd = LenW'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (advance) begin
      v9 <= vd[DabbleStages-1];
    end
    if (advance) begin
      fmt9.digits <= dig;
      fmt9.ndig   <= nd;
      fmt9.neg    <= negd[DabbleStages-1];
      fmt9.len    <= nd + {{(LenW-1){1'b0}}, negd[DabbleStages-1]};
    end
  end

  assign out_valid = v9;
  assign out_fmt   = fmt9;
endmodule
`default_nettype wire

@@ rtl/core/i2a_emit.sv @@
// Character serializer with registered output word.
`default_nettype none
module i2a_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire i2a_pkg::fmt_t      in_fmt,
  i2a_rsp_if.source               rsp
);
  import i2a_pkg::*;

  logic            busy;
  fmt_t            cur;
  logic [LenW-1:0] pos;
  logic            out_free;
  logic            at_last;
  logic [LenW-1:0] didx;
  logic [CharW-1:0] ch;

  assign out_free = !rsp.valid || rsp.ready;
  assign at_last  = (pos == cur.len - 5'd1);
  assign in_ready = !busy || (out_free && at_last);

  // most significant digit first, after an optional minus sign
  assign didx = cur.ndig - 5'd1 - (pos - {{(LenW-1){1'b0}}, cur.neg});

  always_comb begin
    if (cur.neg && pos == '0) ch = CharMinus;
    else ch = digit_char(cur.digits[didx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_free) rsp.valid <= busy;
      if (in_valid && in_ready) busy <= 1'b1;
      else if (busy && out_free && at_last) busy <= 1'b0;
    end
    if (out_free && busy) begin
      rsp.character <= ch;
      rsp.last      <= at_last;
      rsp.length    <= cur.len;
    end
    if (in_valid && in_ready) begin
      cur <= in_fmt;
      pos <= '0;
    end else if (out_free && busy) begin
      pos <= pos + 5'd1;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/integer_to_ascii_radix_core.sv @@
// Top level: 64-bit integer to ASCII text in hex, octal or decimal.
//
//  channel | dir | word
//  req     | in  | kind[1:0], value[63:0]
//  rsp     | out | character[7:0], last, length[4:0]
//
// Ten register stages (magnitude, eight double-dabble stages of eight bits each,
// digit format) feed a serializer that sends one character per cycle while rsp
// is ready; it takes the next item as the last character of the current one goes
// out, for lengths of 1 to 22. A stall on rsp halts the pipeline when its last
// stage is full; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
`default_nettype none
module integer_to_ascii_radix_core (
  input  wire logic clk,
  input  wire logic rst,
  i2a_req_if.sink   req,
  i2a_rsp_if.source rsp
);
  import i2a_pkg::*;

  logic p_valid;
  logic p_ready;
  fmt_t p_fmt;

  i2a_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_kind  (req.kind),
    .in_value (req.value),
    .out_valid(p_valid),
    .out_ready(p_ready),
    .out_fmt  (p_fmt)
  );

  i2a_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .in_valid(p_valid),
    .in_ready(p_ready),
    .in_fmt  (p_fmt),
    .rsp     (rsp)
  );
endmodule
`default_nettype wire

@@ rtl/core/i2a_checker.sv @@
// Checker on the top-level rsp channel, bound to the core.
`default_nettype none
module i2a_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_character,
  input wire logic       rsp_last,
  input wire logic [4:0] rsp_length
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
    else $error("rsp word changed while stalled");

  a_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_length >= 5'd1 && rsp_length <= 5'd22)
    else $error("length out of range");

  a_minus: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_character == 8'h2d |-> !rsp_last && rsp_length >= 5'd2)
    else $error("minus sign at end of string");

  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_length == 5'd1 |-> rsp_last)
    else $error("one-character string without last");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");
endmodule

bind integer_to_ascii_radix_core i2a_checker u_i2a_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_character(rsp.character),
  .rsp_last     (rsp.last),
  .rsp_length   (rsp.length)
);
`default_nettype wire
